// ===== src/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and elaboration-time helpers for the permutation
// and combination counter.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int DEFAULT_RESULT_BITS = 64;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_OVERFLOW       = 2'd1,
    ST_SUBSET_TOO_BIG = 2'd2
  } status_t;

  // Largest n whose factorial still fits in the given number of bits.
  function automatic int fact_limit(input int bits);
    logic [127:0] lim;
    logic [127:0] f;
    int           res;
    lim = (128'd1 << bits) - 128'd1;
    f   = 128'd1;
    res = 0;
    for (int i = 1; i <= 25; i++) begin
      f = f * 128'(i);
      if (f <= lim) begin
        res = i;
      end
    end
    return res;
  endfunction

endpackage

// ===== src/permutation_combination_count_unit.sv =====
// ----------------------------------------------------------------------------
// permutation_combination_count_unit
// Counts ordered (n!/(n-k)!) or unordered (n!/((n-k)!k!)) selections of k
// elements out of n with one shared multiplier and a radix-2 divider.
//
// The slave side takes one transfer per request: s_tdata carries n and k,
// s_tuser carries the mode. The master side returns one transfer per request
// with the count in m_tdata and the status in m_tuser.
// A request with k greater than n, or with n! wider than RESULT_BITS bits,
// is answered with a zero count and an error status, skipping the multiply
// steps. Otherwise a permutation takes k multiply steps; a combination adds
// k multiply steps for k! and RESULT_BITS restoring division steps. s_tready
// returns as the result is loaded, so the unit accepts no new request until
// the result of the last one has moved into the output register.
// The result sits in an output register; a stalled receiver holds it while
// the next request is accepted and computed, and that request waits at its
// final step until the register is free.
// Reset is synchronous and returns the unit to idle with no result pending.
// ----------------------------------------------------------------------------
module permutation_combination_count_unit #(
  parameter int RESULT_BITS = pcc_pkg::DEFAULT_RESULT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] set_size, [15:8] subset_size
  input  logic [0:0]  s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] count
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int         CNT_W = $clog2(RESULT_BITS);
  localparam logic [7:0] N_MAX = 8'(pcc_pkg::fact_limit(RESULT_BITS));

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_FACT,
    S_DIV,
    S_OUT
  } state_t;

  state_t                 state;
  logic                   mode;
  logic [7:0]             k_r;
  logic [7:0]             factor;
  logic [7:0]             left;
  logic [RESULT_BITS-1:0] acc;
  logic [RESULT_BITS-1:0] fk;
  logic [RESULT_BITS-1:0] rem;
  logic [RESULT_BITS-1:0] quo;
  logic [CNT_W-1:0]       cnt;
  pcc_pkg::status_t       stat;

  logic [7:0]             in_n;
  logic [7:0]             in_k;
  logic [RESULT_BITS-1:0] mul_a;
  logic [RESULT_BITS+7:0] product;
  logic [RESULT_BITS:0]   shifted;
  logic                   fits;
  logic [RESULT_BITS-1:0] rem_next;
  logic [RESULT_BITS-1:0] quo_next;

  assign in_n     = s_tdata[7:0];
  assign in_k     = s_tdata[15:8];
  assign s_tready = (state == S_IDLE);

  always_comb begin
    mul_a   = (state == S_FACT) ? fk : acc;
    product = (RESULT_BITS + 8)'(mul_a) * (RESULT_BITS + 8)'(factor);
    shifted = {rem, quo[RESULT_BITS-1]};
    fits    = (shifted >= {1'b0, fk});
    if (fits) begin
      rem_next = RESULT_BITS'(shifted - {1'b0, fk});
    end else begin
      rem_next = shifted[RESULT_BITS-1:0];
    end
    quo_next = {quo[RESULT_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode   <= s_tuser[0];
            k_r    <= in_k;
            factor <= in_n;
            left   <= in_k;
            if (in_k > in_n) begin
              stat  <= pcc_pkg::ST_SUBSET_TOO_BIG;
              acc   <= '0;
              state <= S_OUT;
            end else if (in_n > N_MAX) begin
              stat  <= pcc_pkg::ST_OVERFLOW;
              acc   <= '0;
              state <= S_OUT;
            end else begin
              stat  <= pcc_pkg::ST_OK;
              acc   <= RESULT_BITS'(1);
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          if (left == 8'd0) begin
            if (mode) begin
              fk     <= RESULT_BITS'(1);
              factor <= k_r;
              left   <= k_r;
              state  <= S_FACT;
            end else begin
              state <= S_OUT;
            end
          end else begin
            acc    <= product[RESULT_BITS-1:0];
            factor <= factor - 8'd1;
            left   <= left - 8'd1;
          end
        end
        S_FACT: begin
          if (left == 8'd0) begin
            rem   <= '0;
            quo   <= acc;
            cnt   <= CNT_W'(RESULT_BITS - 1);
            state <= S_DIV;
          end else begin
            fk     <= product[RESULT_BITS-1:0];
            factor <= factor - 8'd1;
            left   <= left - 8'd1;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            acc   <= quo_next;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 64'(acc);
            m_tuser  <= stat;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
